FILE: rtl/assert_macros.svh
// Assertion macros used by the checker in smeu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");

`define CHK_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");

`endif

FILE: rtl/smeu_pkg.sv
package smeu_pkg;

    localparam int StackDepth  = 64;
    localparam int ReturnDepth = 16;
    localparam int DataDepth   = 256;
    localparam int PcBits      = 16;

    localparam int SpW = $clog2(StackDepth + 1);
    localparam int SaW = $clog2(StackDepth);
    localparam int RpW = $clog2(ReturnDepth + 1);
    localparam int RaW = (ReturnDepth > 1) ? $clog2(ReturnDepth) : 1;
    localparam int ExW = $clog2(DataDepth + 1);
    localparam int DaW = (DataDepth > 1) ? $clog2(DataDepth) : 1;

    typedef enum logic [4:0] {
        OP_NOP = 5'd0, OP_EXIT = 5'd1, OP_PUSHI = 5'd2, OP_POP = 5'd3,
        OP_LOAD = 5'd4, OP_STORE = 5'd5, OP_DUP = 5'd6, OP_SWAP = 5'd7,
        OP_ADD = 5'd8, OP_NEG = 5'd9, OP_MUL = 5'd10, OP_DIV = 5'd11,
        OP_PRINTNUM = 5'd12, OP_PRINTSTR = 5'd13, OP_JUMP = 5'd14, OP_JZ = 5'd15,
        OP_JNZ = 5'd16, OP_CALL = 5'd17, OP_RET = 5'd18, OP_ALLOC = 5'd19
    } t_op;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NUM  = 2'd1;
    localparam logic [1:0] KIND_STR  = 2'd2;
    localparam logic [1:0] KIND_HALT = 2'd3;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_SUNDER  = 3'd1;
    localparam logic [2:0] ERR_SOVER   = 3'd2;
    localparam logic [2:0] ERR_RUNDER  = 3'd3;
    localparam logic [2:0] ERR_ROVER   = 3'd4;
    localparam logic [2:0] ERR_DIVZERO = 3'd5;
    localparam logic [2:0] ERR_ADDR    = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic div_start;
        logic div_done_wr;
        logic out_taken;
    } t_cmd;

    typedef struct packed {
        logic is_div;
        logic is_mul;
        logic div_busy;
    } t_status;

endpackage

FILE: rtl/smeu_divider.sv
module smeu_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_q, n_q, r_d;
    logic [32:0] r_rem, n_rem, w_try;
    logic        r_neg;

    always_comb begin
        n_cnt = r_cnt;
        n_q = r_q;
        n_rem = r_rem;
        w_try = {r_rem[31:0], r_q[31]} - {1'b0, r_d};
        if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (!w_try[32]) begin
                n_rem = w_try;
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_q[31]};
                n_q = {r_q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_q   <= i_num[31] ? (32'd0 - i_num) : i_num;
            r_d   <= i_den[31] ? (32'd0 - i_den) : i_den;
            r_rem <= 33'd0;
            r_neg <= i_num[31] ^ i_den[31];
        end else begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_neg ? (32'd0 - r_q) : r_q;
endmodule

FILE: rtl/smeu_datapath.sv
module smeu_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smeu_pkg::t_cmd        i_cmd,
    output smeu_pkg::t_status     o_status,
    input  logic [4:0]            i_func,
    input  logic [31:0]           i_operand,
    output logic [15:0]           o_next_pc,
    output logic [1:0]            o_kind,
    output logic [31:0]           o_value,
    output logic [2:0]            o_err
);
    logic [31:0] r_stk [smeu_pkg::StackDepth];
    logic [15:0] r_rst [smeu_pkg::ReturnDepth];
    logic [31:0] r_mem [smeu_pkg::DataDepth];
    logic [smeu_pkg::DataDepth-1:0] r_mvalid;

    logic [smeu_pkg::SpW-1:0]    r_sp, n_sp;
    logic [smeu_pkg::RpW-1:0]    r_rp, n_rp;
    logic [smeu_pkg::ExW-1:0]    r_ext, n_ext;
    logic [smeu_pkg::PcBits-1:0] r_pc, n_pc;
    logic                        r_halt, n_halt;
    logic [4:0]                  r_func;
    logic [31:0]                 r_opnd;
    logic [31:0]                 r_a, r_b, r_md;
    logic [15:0]                 r_rd;
    logic                        r_mv;
    logic [15:0]                 r_npc;
    logic [1:0]                  r_kind;
    logic [31:0]                 r_val;
    logic [2:0]                  r_err;
    logic [31:0]                 r_prod;

    logic [smeu_pkg::SaW-1:0] w_ia, w_ib, w_wa, w_wb;
    logic [smeu_pkg::RaW-1:0] w_ra, w_rw;
    logic [smeu_pkg::DaW-1:0] w_da;
    logic        w_we1, w_we2, w_rwe, w_mwe;
    logic [31:0] w_wd1, w_wd2, w_md, w_dq;
    logic [1:0]  w_kind;
    logic [31:0] w_val;
    logic [2:0]  w_err;
    logic        w_dbusy;
    logic        w_addr_ok, w_tgt_ok, w_take, w_alloc_ok;
    logic [smeu_pkg::PcBits-1:0] w_pc1, w_tgt;
    logic [32:0] w_extsum;
    logic [31:0] w_a, w_b;

    smeu_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_a), .i_den(r_b), .o_busy(w_dbusy), .o_quot(w_dq)
    );

    assign o_status.is_div   = (r_func == smeu_pkg::OP_DIV) && !r_halt
                               && (w_err == smeu_pkg::ERR_OK);
    assign o_status.is_mul   = (r_func == smeu_pkg::OP_MUL) && !r_halt
                               && (w_err == smeu_pkg::ERR_OK);
    assign o_status.div_busy = w_dbusy;

    assign w_ia = smeu_pkg::SaW'(r_sp - smeu_pkg::SpW'(1));
    assign w_ib = smeu_pkg::SaW'(r_sp - smeu_pkg::SpW'(2));
    assign w_ra = smeu_pkg::RaW'(r_rp - smeu_pkg::RpW'(1));
    assign w_da = smeu_pkg::DaW'(r_opnd);
    assign w_a  = r_a;
    assign w_b  = r_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_opnd <= i_operand;
        end
        if (i_cmd.read) begin
            r_a  <= r_stk[w_ia];
            r_b  <= r_stk[w_ib];
            r_rd <= 16'(r_rst[w_ra]);
            r_md <= r_mem[w_da];
            r_mv <= r_mvalid[w_da];
        end
        if (i_cmd.exec) begin
            r_prod <= r_a * r_b;
        end
    end

    assign w_pc1     = r_pc + smeu_pkg::PcBits'(1);
    assign w_tgt     = smeu_pkg::PcBits'(r_opnd - 32'd1);
    assign w_addr_ok = !r_opnd[31] && ({1'b0, r_opnd} < 33'(r_ext));
    assign w_tgt_ok  = !r_opnd[31] && (r_opnd != 32'd0)
                       && ({1'b0, r_opnd} <= 33'(33'd1 << smeu_pkg::PcBits));
    assign w_extsum  = 33'(r_ext) + {1'b0, r_opnd};
    assign w_alloc_ok = !r_opnd[31] && (w_extsum <= 33'(smeu_pkg::DataDepth));
    assign w_take    = (r_func == smeu_pkg::OP_JZ) ? (w_a == 32'd0) : (w_a != 32'd0);
    assign w_md      = r_mv ? r_md : 32'd0;

    always_comb begin
        n_sp = r_sp; n_rp = r_rp; n_ext = r_ext; n_pc = w_pc1; n_halt = r_halt;
        w_kind = smeu_pkg::KIND_NONE; w_val = 32'd0; w_err = smeu_pkg::ERR_OK;
        w_we1 = 1'b0; w_we2 = 1'b0; w_rwe = 1'b0; w_mwe = 1'b0;
        w_wa = w_ia; w_wb = smeu_pkg::SaW'(r_sp); w_wd1 = 32'd0; w_wd2 = 32'd0;
        w_rw = smeu_pkg::RaW'(r_rp);
        if (r_halt) begin
            w_kind = smeu_pkg::KIND_HALT;
            n_pc = r_pc;
        end else begin
            unique case (r_func)
                smeu_pkg::OP_EXIT: begin
                    n_halt = 1'b1; w_kind = smeu_pkg::KIND_HALT; n_pc = r_pc;
                end
                smeu_pkg::OP_PUSHI: begin
                    if (r_sp >= smeu_pkg::SpW'(smeu_pkg::StackDepth)) begin
                        w_err = smeu_pkg::ERR_SOVER;
                    end else begin
                        w_we2 = 1'b1; w_wd2 = r_opnd; n_sp = r_sp + 1'b1;
                    end
                end
                smeu_pkg::OP_POP: begin
                    if (r_sp == 0) w_err = smeu_pkg::ERR_SUNDER;
                    else n_sp = r_sp - 1'b1;
                end
                smeu_pkg::OP_LOAD: begin
                    if (!w_addr_ok) w_err = smeu_pkg::ERR_ADDR;
                    else if (r_sp >= smeu_pkg::SpW'(smeu_pkg::StackDepth))
                        w_err = smeu_pkg::ERR_SOVER;
                    else begin
                        w_we2 = 1'b1; w_wd2 = w_md; n_sp = r_sp + 1'b1;
                    end
                end
                smeu_pkg::OP_STORE: begin
                    if (!w_addr_ok) w_err = smeu_pkg::ERR_ADDR;
                    else if (r_sp == 0) w_err = smeu_pkg::ERR_SUNDER;
                    else begin
                        w_mwe = 1'b1; n_sp = r_sp - 1'b1;
                    end
                end
                smeu_pkg::OP_DUP: begin
                    if (r_sp == 0) w_err = smeu_pkg::ERR_SUNDER;
                    else if (r_sp >= smeu_pkg::SpW'(smeu_pkg::StackDepth))
                        w_err = smeu_pkg::ERR_SOVER;
                    else begin
                        w_we2 = 1'b1; w_wd2 = w_a; n_sp = r_sp + 1'b1;
                    end
                end
                smeu_pkg::OP_SWAP, smeu_pkg::OP_ADD, smeu_pkg::OP_MUL,
                smeu_pkg::OP_DIV: begin
                    if (r_sp < smeu_pkg::SpW'(2)) w_err = smeu_pkg::ERR_SUNDER;
                    else if (r_func == smeu_pkg::OP_DIV && w_b == 32'd0)
                        w_err = smeu_pkg::ERR_DIVZERO;
                    else begin
                        w_wb = w_ib;
                        if (r_func == smeu_pkg::OP_SWAP) begin
                            w_we1 = 1'b1; w_wd1 = w_b;
                            w_we2 = 1'b1; w_wd2 = w_a;
                        end else begin
                            n_sp = r_sp - 1'b1;
                            w_we2 = 1'b1;
                            w_wd2 = (r_func == smeu_pkg::OP_ADD) ? (w_a + w_b) :
                                    (r_func == smeu_pkg::OP_MUL) ? r_prod : w_dq;
                        end
                    end
                end
                smeu_pkg::OP_NEG: begin
                    if (r_sp == 0) w_err = smeu_pkg::ERR_SUNDER;
                    else begin
                        w_wb = w_ia; w_we2 = 1'b1; w_wd2 = 32'd0 - w_a;
                    end
                end
                smeu_pkg::OP_PRINTNUM: begin
                    if (r_sp == 0) w_err = smeu_pkg::ERR_SUNDER;
                    else begin
                        w_kind = smeu_pkg::KIND_NUM; w_val = w_a; n_sp = r_sp - 1'b1;
                    end
                end
                smeu_pkg::OP_PRINTSTR: begin
                    w_kind = smeu_pkg::KIND_STR; w_val = r_opnd;
                end
                smeu_pkg::OP_JUMP: begin
                    if (!w_tgt_ok) w_err = smeu_pkg::ERR_ADDR;
                    else n_pc = w_tgt;
                end
                smeu_pkg::OP_JZ, smeu_pkg::OP_JNZ: begin
                    if (r_sp == 0) w_err = smeu_pkg::ERR_SUNDER;
                    else if (w_take && !w_tgt_ok) w_err = smeu_pkg::ERR_ADDR;
                    else begin
                        n_sp = r_sp - 1'b1;
                        if (w_take) n_pc = w_tgt;
                    end
                end
                smeu_pkg::OP_CALL: begin
                    if (r_rp >= smeu_pkg::RpW'(smeu_pkg::ReturnDepth))
                        w_err = smeu_pkg::ERR_ROVER;
                    else if (!w_tgt_ok) w_err = smeu_pkg::ERR_ADDR;
                    else begin
                        w_rwe = 1'b1; n_rp = r_rp + 1'b1; n_pc = w_tgt;
                    end
                end
                smeu_pkg::OP_RET: begin
                    if (r_rp == 0) w_err = smeu_pkg::ERR_RUNDER;
                    else begin
                        n_rp = r_rp - 1'b1; n_pc = smeu_pkg::PcBits'(r_rd);
                    end
                end
                smeu_pkg::OP_ALLOC: begin
                    if (!w_alloc_ok) w_err = smeu_pkg::ERR_ADDR;
                    else n_ext = smeu_pkg::ExW'(w_extsum);
                end
                default: begin
                end
            endcase
            if (w_err != smeu_pkg::ERR_OK) begin
                n_sp = r_sp; n_rp = r_rp; n_ext = r_ext; n_pc = r_pc;
                w_kind = smeu_pkg::KIND_NONE; w_val = 32'd0;
                w_we1 = 1'b0; w_we2 = 1'b0; w_rwe = 1'b0; w_mwe = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_done_wr) begin
            if (w_we1) r_stk[w_wa] <= w_wd1;
            if (w_we2) r_stk[w_wb] <= w_wd2;
            if (w_rwe) r_rst[w_rw] <= 16'(w_pc1);
            if (w_mwe) r_mem[w_da] <= w_a;
            r_npc  <= 16'(n_pc);
            r_kind <= w_kind;
            r_val  <= w_val;
            r_err  <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0; r_rp <= '0; r_ext <= '0; r_pc <= '0; r_halt <= 1'b0;
            r_mvalid <= '0;
        end else if (i_cmd.div_done_wr) begin
            r_sp <= n_sp; r_rp <= n_rp; r_ext <= n_ext; r_pc <= n_pc; r_halt <= n_halt;
            if (w_mwe) r_mvalid[w_da] <= 1'b1;
        end
    end

    assign o_next_pc = r_npc;
    assign o_kind    = r_kind;
    assign o_value   = r_val;
    assign o_err     = r_err;
endmodule

FILE: rtl/smeu_ctrl.sv
module smeu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  smeu_pkg::t_status  i_status,
    output smeu_pkg::t_cmd     o_cmd
);
    smeu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= smeu_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            smeu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = smeu_pkg::ST_READ;
                end
            end
            smeu_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                n_state = smeu_pkg::ST_EXEC;
            end
            smeu_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = smeu_pkg::ST_DIV;
                end else if (i_status.is_mul) begin
                    n_state = smeu_pkg::ST_DIV;
                end else begin
                    o_cmd.div_done_wr = 1'b1;
                    n_state = smeu_pkg::ST_OUT;
                end
            end
            smeu_pkg::ST_DIV: begin
                o_cmd.exec = 1'b1;
                if (!i_status.div_busy) begin
                    o_cmd.div_done_wr = 1'b1;
                    n_state = smeu_pkg::ST_OUT;
                end
            end
            smeu_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_taken = 1'b1;
                    n_state = smeu_pkg::ST_IDLE;
                end
            end
            default: n_state = smeu_pkg::ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/stack_machine_execute_unit.sv
// Executes one decoded stack-machine instruction per input transaction and returns one
// result transaction. An instruction passes through four steps (capture, stack and memory read,
// execute and write back, output). An error-free multiplication also passes through the
// divider wait state for its registered product, and an error-free division waits there
// for the shift-subtract divider. A new transaction is accepted once the previous
// result has been taken.
module stack_machine_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // func[4:0], operand[36:5], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // next_pc[15:0], out_kind[17:16],
                                       // out_value[49:18], error_code[52:50], zero fill
);
    smeu_pkg::t_cmd    w_cmd;
    smeu_pkg::t_status w_status;
    logic [15:0] w_npc;
    logic [1:0]  w_kind;
    logic [31:0] w_val;
    logic [2:0]  w_err;

    smeu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    smeu_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_func(s_axis_tdata[4:0]), .i_operand(s_axis_tdata[36:5]),
        .o_next_pc(w_npc), .o_kind(w_kind), .o_value(w_val), .o_err(w_err)
    );

    assign m_axis_tdata = {3'd0, w_err, w_val, w_kind, w_npc};
endmodule

FILE: rtl/smeu_checker.sv
`include "assert_macros.svh"
module smeu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    `CHK_IMPLIES(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `CHK_NEXT(a_accept_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CHK_IMPLIES(a_err_quiet, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[52:50] != smeu_pkg::ERR_OK,
        m_axis_tdata[17:16] == smeu_pkg::KIND_NONE && m_axis_tdata[49:18] == 32'd0)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind stack_machine_execute_unit smeu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
